### src/wtm_pkg.sv
// Shared types and constants for the windowed throughput meter.
// No dependencies; used by wtm_engine and windowed_throughput_meter.
`default_nettype none

package wtm_pkg;

	// field widths
	localparam int TS_W     = 64;
	localparam int PKT_W    = 19;
	localparam int ELAP_W   = 48;
	localparam int RATE_W   = 32;
	localparam int PCOUNT_W = 16;
	localparam int CFG_IDX_W = 2;

	// scale constants and the widths they need
	localparam int US_MUL_W   = 20;
	localparam int KBIT_MUL_W = 10;
	localparam logic [US_MUL_W-1:0]   USEC_PER_SEC  = US_MUL_W'(1000000);
	localparam logic [KBIT_MUL_W-1:0] BITS_PER_KBIT = KBIT_MUL_W'(1000);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TPS       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PKT_LIMIT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_TS  = 2'd3;

	// configuration reset values
	localparam logic                RST_ENABLE    = 1'b1;
	localparam logic [TS_W-1:0]     RST_TPS       = TS_W'(1000000000);
	localparam logic [PCOUNT_W-1:0] RST_PKT_LIMIT = PCOUNT_W'(100);
	localparam logic [TS_W-1:0]     RST_START_TS  = '0;

	typedef enum logic [1:0] {
		ENG_IDLE,
		ENG_MUL,
		ENG_DIV,
		ENG_DONE
	} eng_state_t;

	typedef enum logic [1:0] {
		TOP_IDLE,
		TOP_CALC,
		TOP_HOLD
	} top_state_t;

endpackage

`default_nettype wire

### src/wtm_engine.sv
// Bit-serial multiply and restoring-divide engine for one window close.
// Depends on wtm_pkg.
`default_nettype none

module wtm_engine #(
	parameter int BIT_TOTAL_WIDTH = 40
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [wtm_pkg::TS_W-1:0]      run_ticks,
	input  wire logic [wtm_pkg::TS_W-1:0]      window_ticks,
	input  wire logic [BIT_TOTAL_WIDTH-1:0]    bit_total,
	input  wire logic [wtm_pkg::TS_W-1:0]      tps,
	output logic                               done,
	output logic [wtm_pkg::ELAP_W-1:0]         elapsed,
	output logic [wtm_pkg::RATE_W-1:0]         rate
);

	localparam int NUM_W  = wtm_pkg::TS_W + BIT_TOTAL_WIDTH;
	localparam int DEN2_W = wtm_pkg::TS_W + wtm_pkg::KBIT_MUL_W;
	localparam int CNT_W  = $clog2(NUM_W);
	localparam int TS_W   = wtm_pkg::TS_W;
	localparam int ELAP_W = wtm_pkg::ELAP_W;
	localparam int RATE_W = wtm_pkg::RATE_W;

	wtm_pkg::eng_state_t state_q, state_d;

	logic [CNT_W-1:0]           cnt_q;
	logic [BIT_TOTAL_WIDTH-1:0] mb_q, mc1_q, mc2_q;
	logic [TS_W-1:0]            run_ticks_q, window_ticks_q;
	logic [NUM_W-1:0]           a1_q, a2_q, a3_q;
	logic [TS_W:0]              rem1_q;
	logic [DEN2_W:0]            rem2_q;
	logic [ELAP_W-1:0]          q1_q;
	logic [RATE_W-1:0]          q2_q;
	logic                       sat1_q, sat2_q;

	logic mul_en, div_en;
	logic mul_last, div_last;

	logic [NUM_W-1:0] add1, add2, add3;
	logic [TS_W:0]    t1, d1;
	logic [DEN2_W:0]  t2, d2;
	logic             ge1, ge2;

	assign mul_last = (cnt_q == CNT_W'(BIT_TOTAL_WIDTH - 1));
	assign div_last = (cnt_q == CNT_W'(NUM_W - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wtm_pkg::ENG_IDLE: if (start) state_d = wtm_pkg::ENG_MUL;
			wtm_pkg::ENG_MUL:  if (mul_last) state_d = wtm_pkg::ENG_DIV;
			wtm_pkg::ENG_DIV:  if (div_last) state_d = wtm_pkg::ENG_DONE;
			wtm_pkg::ENG_DONE: state_d = wtm_pkg::ENG_IDLE;
			default:           state_d = wtm_pkg::ENG_IDLE;
		endcase
	end

	always_comb begin
		mul_en = (state_q == wtm_pkg::ENG_MUL);
		div_en = (state_q == wtm_pkg::ENG_DIV);
		done   = (state_q == wtm_pkg::ENG_DONE);
	end

	// shift-add partial products, multiplier bits taken MSB first
	assign add1 = mc1_q[BIT_TOTAL_WIDTH-1] ? NUM_W'(run_ticks_q) : '0;
	assign add2 = mb_q[BIT_TOTAL_WIDTH-1]  ? NUM_W'(tps) : '0;
	assign add3 = mc2_q[BIT_TOTAL_WIDTH-1] ? NUM_W'(window_ticks_q) : '0;

	// one restoring-division step per cycle on each quotient
	assign t1  = {rem1_q[TS_W-1:0], a1_q[NUM_W-1]};
	assign d1  = {1'b0, tps};
	assign ge1 = (t1 >= d1);
	assign t2  = {rem2_q[DEN2_W-1:0], a2_q[NUM_W-1]};
	assign d2  = {1'b0, a3_q[DEN2_W-1:0]};
	assign ge2 = (t2 >= d2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wtm_pkg::ENG_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (start || (mul_en && mul_last) || div_en && div_last)
				cnt_q <= '0;
			else if (mul_en || div_en)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mb_q           <= bit_total;
			mc1_q          <= BIT_TOTAL_WIDTH'(wtm_pkg::USEC_PER_SEC);
			mc2_q          <= BIT_TOTAL_WIDTH'(wtm_pkg::BITS_PER_KBIT);
			run_ticks_q    <= run_ticks;
			window_ticks_q <= window_ticks;
			a1_q           <= '0;
			a2_q           <= '0;
			a3_q           <= '0;
		end else if (mul_en) begin
			mb_q  <= {mb_q[BIT_TOTAL_WIDTH-2:0], 1'b0};
			mc1_q <= {mc1_q[BIT_TOTAL_WIDTH-2:0], 1'b0};
			mc2_q <= {mc2_q[BIT_TOTAL_WIDTH-2:0], 1'b0};
			a1_q  <= {a1_q[NUM_W-2:0], 1'b0} + add1;
			a2_q  <= {a2_q[NUM_W-2:0], 1'b0} + add2;
			a3_q  <= {a3_q[NUM_W-2:0], 1'b0} + add3;
			if (mul_last) begin
				rem1_q <= '0;
				rem2_q <= '0;
				q1_q   <= '0;
				q2_q   <= '0;
				sat1_q <= 1'b0;
				sat2_q <= 1'b0;
			end
		end else if (div_en) begin
			// products now serve as numerators; shift them out MSB first
			a1_q   <= {a1_q[NUM_W-2:0], 1'b0};
			a2_q   <= {a2_q[NUM_W-2:0], 1'b0};
			rem1_q <= ge1 ? (t1 - d1) : t1;
			rem2_q <= ge2 ? (t2 - d2) : t2;
			q1_q   <= {q1_q[ELAP_W-2:0], ge1};
			q2_q   <= {q2_q[RATE_W-2:0], ge2};
			sat1_q <= sat1_q | q1_q[ELAP_W-1];
			sat2_q <= sat2_q | q2_q[RATE_W-1];
		end
	end

	assign elapsed = sat1_q ? '1 : q1_q;
	assign rate    = sat2_q ? '1 : q2_q;

endmodule

`default_nettype wire

### src/windowed_throughput_meter.sv
// Windowed throughput meter: top level with config registers, window state
// and result register. Depends on wtm_pkg and wtm_engine.
//
// Packet requests arrive on in_valid/in_stall with timestamp and packet_bits;
// one is taken when in_valid is high and in_stall is low. A request that
// keeps the window open leaves in_stall low, so such requests may follow
// back to back. A request that closes the window starts the serial engine:
// a shift-add multiply, a restoring divide and a one-cycle done strobe.
// The result register loads when the engine is done and in_stall drops
// with it; until then in_stall stays high and no request is taken.
// Results leave on out_valid/out_stall from the output register; while the
// receiver stalls, the register holds its result and the block keeps taking
// requests that do not close a window. A closing result that finds the
// register still full holds in the engine, with in_stall high, until the
// register drains.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Reset loads the default configuration, opens the
// window at time zero with empty counts and clears out_valid.
`default_nettype none

module windowed_throughput_meter #(
	parameter int BIT_TOTAL_WIDTH = 40
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// packet events
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [wtm_pkg::TS_W-1:0]          timestamp,
	input  wire logic [wtm_pkg::PKT_W-1:0]         packet_bits,
	// window reports
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [wtm_pkg::ELAP_W-1:0]             elapsed_us,
	output logic [wtm_pkg::RATE_W-1:0]             rate_kbps,
	// configuration writes
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [wtm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [wtm_pkg::TS_W-1:0]          cfg_data
);

	localparam int TS_W = wtm_pkg::TS_W;
	localparam int PC_W = wtm_pkg::PCOUNT_W;

	// configuration
	logic                 enable_q;
	logic [TS_W-1:0]      tps_q;
	logic [PC_W-1:0]      pkt_limit_q;
	logic [TS_W-1:0]      start_ts_q;

	// window state
	logic [TS_W-1:0]            win_start_q;
	logic [BIT_TOTAL_WIDTH-1:0] bit_total_q;
	logic [PC_W-1:0]            pkt_count_q;

	wtm_pkg::top_state_t state_q, state_d;

	logic                         out_valid_q;
	logic [wtm_pkg::ELAP_W-1:0]   elapsed_q;
	logic [wtm_pkg::RATE_W-1:0]   rate_q;

	logic                         accept, metered, close_win, eng_start, out_free, load_out;
	logic [TS_W-1:0]              win_ticks, run_ticks;
	logic [BIT_TOTAL_WIDTH-1:0]   base_total, next_total;
	logic [BIT_TOTAL_WIDTH:0]     total_sum;
	logic [PC_W-1:0]              next_count;
	logic                         eng_done;
	logic [wtm_pkg::ELAP_W-1:0]   eng_elapsed;
	logic [wtm_pkg::RATE_W-1:0]   eng_rate;

	assign cfg_ready = 1'b1;

	// Write a register; the index space is fully decoded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= wtm_pkg::RST_ENABLE;
			tps_q       <= wtm_pkg::RST_TPS;
			pkt_limit_q <= wtm_pkg::RST_PKT_LIMIT;
			start_ts_q  <= wtm_pkg::RST_START_TS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wtm_pkg::CFG_ENABLE:    enable_q    <= cfg_data[0];
				wtm_pkg::CFG_TPS:       tps_q       <= cfg_data;
				wtm_pkg::CFG_PKT_LIMIT: pkt_limit_q <= cfg_data[PC_W-1:0];
				wtm_pkg::CFG_START_TS:  start_ts_q  <= cfg_data;
			endcase
		end
	end

	assign accept  = in_valid && !in_stall;
	assign metered = accept && enable_q;

	// Check the open window before counting the new packet; differences wrap.
	assign win_ticks = timestamp - win_start_q;
	assign run_ticks = timestamp - start_ts_q;
	assign close_win = (pkt_count_q >= pkt_limit_q) || (tps_q <= win_ticks);

	// Add the packet to the (possibly reopened) window, saturating both counts.
	assign base_total = close_win ? '0 : bit_total_q;
	assign total_sum  = {1'b0, base_total} + (BIT_TOTAL_WIDTH + 1)'(packet_bits);
	assign next_total = total_sum[BIT_TOTAL_WIDTH] ? '1 : total_sum[BIT_TOTAL_WIDTH-1:0];

	always_comb begin
		if (close_win)
			next_count = PC_W'(1);
		else if (pkt_count_q == '1)
			next_count = pkt_count_q;
		else
			next_count = pkt_count_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_start_q <= '0;
			bit_total_q <= '0;
			pkt_count_q <= '0;
		end else if (metered) begin
			if (close_win)
				win_start_q <= timestamp;
			bit_total_q <= next_total;
			pkt_count_q <= next_count;
		end
	end

	// Request sequencing: idle, engine busy, result waiting for the register.
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wtm_pkg::TOP_IDLE: if (metered && close_win) state_d = wtm_pkg::TOP_CALC;
			wtm_pkg::TOP_CALC: begin
				if (eng_done)
					state_d = out_free ? wtm_pkg::TOP_IDLE : wtm_pkg::TOP_HOLD;
			end
			wtm_pkg::TOP_HOLD: if (out_free) state_d = wtm_pkg::TOP_IDLE;
			default:           state_d = wtm_pkg::TOP_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != wtm_pkg::TOP_IDLE);
		eng_start = metered && close_win;
		load_out  = out_free && ((state_q == wtm_pkg::TOP_CALC && eng_done) ||
			state_q == wtm_pkg::TOP_HOLD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= wtm_pkg::TOP_IDLE;
		else
			state_q <= state_d;
	end

	// The engine latches the closed window's figures at start.
	wtm_engine #(
		.BIT_TOTAL_WIDTH(BIT_TOTAL_WIDTH)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (eng_start),
		.run_ticks    (run_ticks),
		.window_ticks (win_ticks),
		.bit_total    (bit_total_q),
		.tps          (tps_q),
		.done         (eng_done),
		.elapsed      (eng_elapsed),
		.rate         (eng_rate)
	);

	// Output register: hold while stalled, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			elapsed_q <= eng_elapsed;
			rate_q    <= eng_rate;
		end
	end

	assign out_valid  = out_valid_q;
	assign elapsed_us = elapsed_q;
	assign rate_kbps  = rate_q;

endmodule

`default_nettype wire
